/* design/first_seen_name_table_unit_macros.svh */
// Assertion helpers for the checker file of this block.
`ifndef FIRST_SEEN_NAME_TABLE_UNIT_MACROS_SVH
`define FIRST_SEEN_NAME_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSNT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("fsnt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSNT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("fsnt assertion failed");

`endif

/* design/fsnt_pkg.sv */
package fsnt_pkg;

  localparam int MaxEntries = 512;
  localparam int NameBytes  = 32;
  localparam int TokMax     = NameBytes - 1;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int TlenW      = $clog2(NameBytes + 1);
  localparam int NlenW      = $clog2(NameBytes);
  localparam int PosW       = $clog2(TokMax);
  localparam int TimeW      = 64;
  localparam int NameW      = TokMax * 8;
  localparam int RowW       = NameW + NlenW + TimeW;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharNl    = 8'h0a;
  localparam logic [7:0] CharNul   = 8'h00;

  localparam logic ModeFeed = 1'b0;
  localparam logic ModeRead = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  text_byte;
    logic        end_of_buffer;
    logic [63:0] scan_time;
    logic [8:0]  read_index;
    logic [4:0]  read_char_pos;
  } in_word_t;

  typedef struct packed {
    logic        token_done;
    logic        token_inserted;
    logic [8:0]  token_index;
    logic [9:0]  entry_count;
    logic        overflow_seen;
    logic [7:0]  name_char;
    logic [4:0]  name_length;
    logic [63:0] first_seen_time;
  } out_word_t;

endpackage

/* design/fsnt_ram.sv */
module fsnt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/first_seen_name_table_unit.sv */
// First-seen name table. Text bytes arrive one word at a time (mode 0); the
// first token of each line, ended by a space, a newline, a zero byte or the
// end-of-buffer mark, is looked up among the stored names, and a token of 1
// to 31 bytes that is new is appended together with the word's scan time.
// When the table is full the sticky overflow flag is set instead. A mode 1
// word reads one byte, the length and the first-seen time of a stored entry.
// Every input word yields exactly one result word. A byte that ends a valid
// token starts a lookup that walks the stored names, reading one table row
// per cycle from the single name memory port (a hit stops the walk early).
// The next word is accepted as soon as the previous result sits in the
// output register, even while the receiver stalls it. The table memory needs
// no clearing after reset: only rows below the stored count are ever used.
module first_seen_name_table_unit
  import fsnt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StRead   = 2'd1;
  localparam logic [1:0] StSearch = 2'd2;
  localparam logic [1:0] StResult = 2'd3;

  // Control state.
  logic [1:0]      state_q, state_d;
  logic [TlenW-1:0] tok_len_q, tok_len_d;
  logic            phase_q, phase_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic            cmp_valid_q, cmp_valid_d;
  logic            out_valid_q, out_valid_d;

  // Payload state.
  logic [7:0]       tok_buf_q [TokMax];
  logic [7:0]       tok_buf_d [TokMax];
  logic [NlenW-1:0] srch_len_q, srch_len_d;
  logic [TimeW-1:0] time_q, time_d;
  logic [8:0]       ridx_q, ridx_d;
  logic [4:0]       rpos_q, rpos_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  out_word_t        res_q, res_d;
  out_word_t        out_q, out_d;

  // Table memory: one row per entry holds {time, length, name bytes}.
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [RowW-1:0] ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  logic [RowW-1:0] ram_rdata;

  fsnt_ram #(
    .Width(RowW),
    .Depth(MaxEntries)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic [7:0]       rd_bytes [TokMax];
  logic [NlenW-1:0] rd_len;
  logic [TimeW-1:0] rd_time;
  logic [NameW-1:0] wr_name;

  always_comb begin
    for (int k = 0; k < TokMax; k++) begin
      rd_bytes[k] = ram_rdata[k*8 +: 8];
      wr_name[k*8 +: 8] = tok_buf_q[k];
    end
    rd_len  = ram_rdata[NameW +: NlenW];
    rd_time = ram_rdata[NameW+NlenW +: TimeW];
  end

  // A stored row matches when its length equals the token length and the
  // bytes below that length agree.
  logic match;
  always_comb begin
    match = cmp_valid_q && (rd_len == srch_len_q);
    for (int k = 0; k < TokMax; k++) begin
      if ((k < int'(srch_len_q)) && (rd_bytes[k] != tok_buf_q[k])) begin
        match = 1'b0;
      end
    end
  end

  logic in_acc;
  assign in_acc     = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);

  // Byte scanner for mode 0 words.
  logic [7:0]       c;
  logic             is_delim;
  logic             ended;
  logic             fin;
  logic [TlenW-1:0] len_after;
  logic             valid_tok;

  always_comb begin
    c         = in_data_i.text_byte;
    is_delim  = (c == CharSpace) || (c == CharNl) || (c == CharNul);
    ended     = 1'b0;
    fin       = 1'b0;
    len_after = tok_len_q;
    phase_d   = phase_q;
    if (!phase_q) begin
      if (is_delim) begin
        fin     = 1'b1;
        ended   = 1'b1;
        phase_d = (c == CharSpace);
      end else if (int'(tok_len_q) < NameBytes) begin
        len_after = tok_len_q + TlenW'(1);
      end
    end else if ((c == CharNl) || (c == CharNul)) begin
      phase_d = 1'b0;
    end
    if (in_data_i.end_of_buffer && !ended) begin
      fin = 1'b1;
    end
    if (in_data_i.end_of_buffer) begin
      phase_d = 1'b0;
    end
    valid_tok = fin && (len_after != '0) && (int'(len_after) <= TokMax);
  end

  always_comb begin
    state_d     = state_q;
    tok_len_d   = tok_len_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    scan_d      = scan_q;
    cmp_valid_d = cmp_valid_q;
    out_valid_d = out_valid_q;
    tok_buf_d   = tok_buf_q;
    srch_len_d  = srch_len_q;
    time_d      = time_q;
    ridx_d      = ridx_q;
    rpos_d      = rpos_q;
    cmp_idx_d   = cmp_idx_q;
    res_d       = res_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[IdxW-1:0];
    ram_wdata   = {time_q, srch_len_q, wr_name};
    ram_raddr   = scan_q[IdxW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          res_d             = '0;
          res_d.entry_count = 10'(count_q);
          res_d.overflow_seen = ovf_q;
          if (in_data_i.mode == ModeRead) begin
            ram_raddr = IdxW'(in_data_i.read_index);
            ridx_d    = in_data_i.read_index;
            rpos_d    = in_data_i.read_char_pos;
            state_d   = StRead;
          end else begin
            if (!phase_q && !is_delim && (int'(tok_len_q) < TokMax)) begin
              tok_buf_d[tok_len_q[PosW-1:0]] = c;
            end
            tok_len_d = (fin || in_data_i.end_of_buffer) ? '0 : len_after;
            if (valid_tok) begin
              srch_len_d  = len_after[NlenW-1:0];
              time_d      = in_data_i.scan_time;
              scan_d      = '0;
              cmp_valid_d = 1'b0;
              state_d     = StSearch;
            end else begin
              state_d = StResult;
            end
          end
        end
      end
      StRead: begin
        if (int'(ridx_q) < int'(count_q)) begin
          if ((int'(rpos_q) < int'(rd_len)) && (int'(rpos_q) < TokMax)) begin
            res_d.name_char = rd_bytes[rpos_q[PosW-1:0]];
          end
          res_d.name_length     = 5'(rd_len);
          res_d.first_seen_time = rd_time;
        end
        state_d = StResult;
      end
      StSearch: begin
        if (match) begin
          res_d.token_done  = 1'b1;
          res_d.token_index = 9'(cmp_idx_q);
          state_d           = StResult;
        end else if (scan_q < count_q) begin
          ram_raddr   = scan_q[IdxW-1:0];
          cmp_idx_d   = scan_q[IdxW-1:0];
          cmp_valid_d = 1'b1;
          scan_d      = scan_q + CntW'(1);
        end else if (cmp_valid_q) begin
          cmp_valid_d = 1'b0;
        end else begin
          res_d.token_done = 1'b1;
          if (int'(count_q) < MaxEntries) begin
            ram_we               = 1'b1;
            res_d.token_inserted = 1'b1;
            res_d.token_index    = 9'(count_q);
            count_d              = count_q + CntW'(1);
            res_d.entry_count    = 10'(count_q + CntW'(1));
          end else begin
            ovf_d               = 1'b1;
            res_d.overflow_seen = 1'b1;
          end
          state_d = StResult;
        end
      end
      StResult: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tok_len_q   <= '0;
      phase_q     <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      scan_q      <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tok_len_q   <= tok_len_d;
      phase_q     <= in_acc && (in_data_i.mode == ModeFeed) ? phase_d : phase_q;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      scan_q      <= scan_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_buf_q  <= tok_buf_d;
    srch_len_q <= srch_len_d;
    time_q     <= time_d;
    ridx_q     <= ridx_d;
    rpos_q     <= rpos_d;
    cmp_idx_q  <= cmp_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/fsnt_checker.sv */
`include "first_seen_name_table_unit_macros.svh"

module fsnt_checker
  import fsnt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_data_o
);

  // A stalled result word stays put.
  `FSNT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // An insert is only reported for a finished token.
  `FSNT_ASSERT_NOW(a_ins_done, clk_i, rst_ni, out_valid_o && out_data_o.token_inserted, out_data_o.token_done)

  // A newly stored name takes the slot just below the new stored count.
  `FSNT_ASSERT_NOW(a_ins_index, clk_i, rst_ni, out_valid_o && out_data_o.token_inserted, out_data_o.token_index == 9'(out_data_o.entry_count - 10'd1))

  // The stored count never exceeds the table size.
  `FSNT_ASSERT_NOW(a_count_max, clk_i, rst_ni, out_valid_o, int'(out_data_o.entry_count) <= MaxEntries)

endmodule

bind first_seen_name_table_unit fsnt_checker u_fsnt_checker (.*);
